@@ sv/gsc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gsc_pkg
// shared types, codes and constant tables of the gas sensor calibrate/convert core
// ----------------------------------------------------------------------------
package gsc_pkg;

   localparam int SAMPLES_AVERAGED = 16;
   localparam int ADC_FULL_SCALE   = 1024;
   localparam int FULL_SUM         = ADC_FULL_SCALE * SAMPLES_AVERAGED;

   localparam logic [29:0] MAX30   = 30'h3FFF_FFFF;
   localparam int FRAC_BITS        = 24;
   localparam int DIV_W            = 56;
   localparam int DIV_CNT_W        = 6;

   // reset values of the csr registers
   localparam logic [31:0] HEAT_WAIT_RESET = 32'd60000;
   localparam logic [31:0] READ_WAIT_RESET = 32'd1000;
   localparam logic [15:0] DIVIDER_RESET   = 16'd2516;

   typedef enum logic [1:0] {
      CSR_HEAT_WAIT   = 2'd0,
      CSR_READ_WAIT   = 2'd1,
      CSR_CLEAN_DIV   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_CAL  = 2'd1,
      OP_READ = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      STAT_NOTHING    = 3'd0,
      STAT_STARTED    = 3'd1,
      STAT_MEASURED   = 3'd2,
      STAT_NOT_CAL    = 3'd3,
      STAT_CALIBRATED = 3'd4,
      STAT_REFUSED    = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RS_START,
      ST_DIV,
      ST_RS_END,
      ST_RS_BRANCH,
      ST_R0_END,
      ST_LOG_NORM,
      ST_LOG_SQ,
      ST_LDIFF,
      ST_MUL,
      ST_E_END,
      ST_EXP,
      ST_SHIFT,
      ST_C_END
   } state_type;

   typedef logic [FRAC_BITS:1][30:0] exp_tab_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] b;
      x = x_in;
      r = 64'd0;
      b = 64'h1 << 62;
      while (b > x) b = b >> 2;
      while (b != 64'd0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^(2^-i) in q1.30 by repeated truncating square roots
   function automatic exp_tab_type build_exp_tab();
      exp_tab_type t;
      logic [63:0] s;
      s = 64'h1 << 31;
      for (int i = 1; i <= FRAC_BITS; i++) begin
         s = isqrt64(s << 30);
         t[i] = s[30:0];
      end
      return t;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_tab();

endpackage
`default_nettype wire

@@ sv/gas_sensor_calibrate_and_convert_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gas_sensor_calibrate_and_convert_core
// tick/calibrate/read sequencer with power-law ppm conversion
// ----------------------------------------------------------------------------
// Each request transaction gives exactly one response transaction. Ticks,
// start calls, refusals, calls before expiry and reads with no reference
// are answered straight from idle. A calibration sample keeps the sequencer
// busy for two passes of the 56-bit restoring divider (Rs, then R0; the Rs
// pass is skipped for a zero or full-scale sum). A measurement takes at most
// one divider pass for Rs, two log2 runs (up to 30 normalize shifts plus 24
// squarings each on the shared 32x32 multiplier), a divide by 25, 24
// exponent steps on the multiplier and a final divide by 10; it ends early
// with a saturated result when Rs is zero or the exponent overflows. One
// request is worked on at a time; req_stall is high while busy or stalled.
module gas_sensor_calibrate_and_convert_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [13:0] req_adc_sum,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_concentration,
   output logic             rsp_calibrating_flag,
   output logic             rsp_reading_flag,
   output logic [29:0]      rsp_r0_value,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   // configuration
   logic [31:0] heat_wait_ff, heat_wait_in;
   logic [31:0] read_wait_ff, read_wait_in;
   logic [15:0] divider_ff, divider_in;

   // control state
   gsc_pkg::state_type state_ff, state_in;
   gsc_pkg::state_type div_next_ff, div_next_in;
   logic        calibrating_ff, calibrating_in;
   logic        reading_ff, reading_in;
   logic [31:0] countdown_ff, countdown_in;
   logic        armed_ff, armed_in;
   logic [29:0] ref_ff, ref_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  status_ff, status_in;
   logic [31:0] conc_ff, conc_in;
   logic        cal_flag_ff, cal_flag_in;
   logic        read_flag_ff, read_flag_in;
   logic [29:0] r0_out_ff, r0_out_in;

   // datapath
   logic        kind_ff, kind_in;            // 1 for a measurement
   logic [13:0] sum_ff, sum_in;
   logic [29:0] rs_ff, rs_in;
   logic [gsc_pkg::DIV_W-1:0] num_ff, num_in;
   logic [gsc_pkg::DIV_W-1:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] den_ff, den_in;
   logic [gsc_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [30:0] m_ff, m_in;
   logic [4:0]  p_ff, p_in;
   logic [23:0] frac_ff, frac_in;
   logic [4:0]  it_ff, it_in;
   logic        lg_sel_ff, lg_sel_in;
   logic [28:0] lg0_ff, lg0_in;
   logic [28:0] lg1_ff, lg1_in;
   logic [28:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic signed [11:0] k_ff, k_in;
   logic [30:0] r_ff, r_in;

   // shared units
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic [16:0] trial;
   logic        trial_ge;

   // helpers
   logic        accept;
   logic        expired;
   logic [31:0] sum_ext;
   logic [31:0] full_minus;
   logic [31:0] t_sq;
   logic [28:0] lg_val;
   logic [29:0] ldiff;
   logic [35:0] q_adj;
   logic [35:0] e_val;
   logic signed [11:0] kk;
   logic [11:0] nsh;
   logic [gsc_pkg::DIV_W-1:0] z_val;
   logic [gsc_pkg::DIV_W-1:0] z9;
   logic [15:0] div_eff;
   logic        load_rsp;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != gsc_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign expired   = armed_ff && (countdown_ff == 32'd0);
   assign sum_ext   = {18'd0, sum_ff};
   assign full_minus = gsc_pkg::FULL_SUM[31:0] - sum_ext;
   assign div_eff   = (divider_ff == 16'd0) ? 16'd1 : divider_ff;

   // shared multiplier
   always_comb begin
      mul_a = {1'b0, m_ff};
      mul_b = {1'b0, m_ff};
      case (state_ff)
         gsc_pkg::ST_MUL: begin
            mul_a = {3'd0, mag_ff};
            mul_b = 32'd37;
         end
         gsc_pkg::ST_EXP: begin
            mul_a = {1'b0, r_ff};
            mul_b = {1'b0, gsc_pkg::EXP_TAB[it_ff]};
         end
         default: begin
            mul_a = {1'b0, m_ff};
            mul_b = {1'b0, m_ff};
         end
      endcase
   end
   assign prod = mul_a * mul_b;

   // restoring divider step
   assign trial    = {rem_ff, num_ff[gsc_pkg::DIV_W-1]};
   assign trial_ge = trial >= {1'b0, den_ff};

   assign t_sq   = prod[61:30];
   assign lg_val = {p_ff, frac_ff[22:0], t_sq[31]};
   assign ldiff  = {1'b0, lg0_ff} - {1'b0, lg1_ff};
   assign q_adj  = quo_ff[35:0] + {35'd0, neg_ff && (rem_ff != 16'd0)};
   assign e_val  = neg_ff ? (36'd0 - q_adj) : q_adj;
   assign kk     = k_ff - 12'sd14;
   assign nsh    = 12'd0 - kk;

   always_comb begin
      if (kk >= 12'sd0) begin
         z_val = {25'd0, r_ff} << kk[4:0];
      end else if (nsh >= 12'd63) begin
         z_val = '0;
      end else begin
         z_val = {25'd0, r_ff} >> nsh[5:0];
      end
   end
   assign z9 = (z_val << 3) + z_val;

   // sequencer and datapath next state
   always_comb begin
      heat_wait_in   = heat_wait_ff;
      read_wait_in   = read_wait_ff;
      divider_in     = divider_ff;
      state_in       = state_ff;
      div_next_in    = div_next_ff;
      calibrating_in = calibrating_ff;
      reading_in     = reading_ff;
      countdown_in   = countdown_ff;
      armed_in       = armed_ff;
      ref_in         = ref_ff;
      kind_in        = kind_ff;
      sum_in         = sum_ff;
      rs_in          = rs_ff;
      num_in         = num_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      den_in         = den_ff;
      cnt_in         = cnt_ff;
      m_in           = m_ff;
      p_in           = p_ff;
      frac_in        = frac_ff;
      it_in          = it_ff;
      lg_sel_in      = lg_sel_ff;
      lg0_in         = lg0_ff;
      lg1_in         = lg1_ff;
      mag_in         = mag_ff;
      neg_in         = neg_ff;
      k_in           = k_ff;
      r_in           = r_ff;
      load_rsp       = 1'b0;
      status_in      = status_ff;
      conc_in        = 32'd0;

      // csr writes
      if (csr_write) begin
         case (csr_index)
            gsc_pkg::CSR_HEAT_WAIT: heat_wait_in = csr_wdata;
            gsc_pkg::CSR_READ_WAIT: read_wait_in = csr_wdata;
            gsc_pkg::CSR_CLEAN_DIV: divider_in   = csr_wdata[15:0];
            default: ;
         endcase
      end

      case (state_ff)
         gsc_pkg::ST_IDLE: begin
            if (accept) begin
               sum_in    = req_adc_sum;
               status_in = gsc_pkg::STAT_NOTHING;
               load_rsp  = 1'b1;
               case (req_operation)
                  gsc_pkg::OP_TICK: begin
                     if (armed_ff && countdown_ff != 32'd0) begin
                        countdown_in = countdown_ff - 32'd1;
                     end
                  end
                  gsc_pkg::OP_CAL: begin
                     if (!calibrating_ff) begin
                        calibrating_in = 1'b1;
                        countdown_in   = heat_wait_ff;
                        armed_in       = 1'b1;
                        status_in      = gsc_pkg::STAT_STARTED;
                     end else if (expired) begin
                        armed_in = 1'b0;
                        kind_in  = 1'b0;
                        load_rsp = 1'b0;
                        state_in = gsc_pkg::ST_RS_START;
                     end
                  end
                  gsc_pkg::OP_READ: begin
                     if (calibrating_ff) begin
                        status_in = gsc_pkg::STAT_REFUSED;
                     end else if (!reading_ff) begin
                        reading_in   = 1'b1;
                        countdown_in = read_wait_ff;
                        armed_in     = 1'b1;
                        status_in    = gsc_pkg::STAT_STARTED;
                     end else if (expired) begin
                        // consumed and re-armed at once
                        countdown_in = read_wait_ff;
                        armed_in     = 1'b1;
                        if (ref_ff != 30'd0) begin
                           kind_in  = 1'b1;
                           load_rsp = 1'b0;
                           state_in = gsc_pkg::ST_RS_START;
                        end else begin
                           status_in = gsc_pkg::STAT_NOT_CAL;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end

         gsc_pkg::ST_RS_START: begin
            if (sum_ext >= gsc_pkg::FULL_SUM[31:0]) begin
               rs_in    = 30'd0;
               state_in = gsc_pkg::ST_RS_BRANCH;
            end else if (sum_ff == 14'd0) begin
               rs_in    = gsc_pkg::MAX30;
               state_in = gsc_pkg::ST_RS_BRANCH;
            end else begin
               num_in      = {8'd0, full_minus, 16'd0};
               den_in      = {2'd0, sum_ff};
               rem_in      = 16'd0;
               cnt_in      = '0;
               div_next_in = gsc_pkg::ST_RS_END;
               state_in    = gsc_pkg::ST_DIV;
            end
         end

         gsc_pkg::ST_DIV: begin
            rem_in = trial_ge ? (trial[15:0] - den_ff) : trial[15:0];
            quo_in = {quo_ff[gsc_pkg::DIV_W-2:0], trial_ge};
            num_in = num_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == gsc_pkg::DIV_CNT_W'(gsc_pkg::DIV_W - 1)) begin
               state_in = div_next_ff;
            end
         end

         gsc_pkg::ST_RS_END: begin
            rs_in    = (quo_ff > {26'd0, gsc_pkg::MAX30}) ? gsc_pkg::MAX30 : quo_ff[29:0];
            state_in = gsc_pkg::ST_RS_BRANCH;
         end

         gsc_pkg::ST_RS_BRANCH: begin
            if (!kind_ff) begin
               num_in      = {18'd0, rs_ff, 8'd0};
               den_in      = div_eff;
               rem_in      = 16'd0;
               cnt_in      = '0;
               div_next_in = gsc_pkg::ST_R0_END;
               state_in    = gsc_pkg::ST_DIV;
            end else if (rs_ff == 30'd0) begin
               status_in = gsc_pkg::STAT_MEASURED;
               conc_in   = 32'hFFFF_FFFF;
               load_rsp  = 1'b1;
               state_in  = gsc_pkg::ST_IDLE;
            end else begin
               m_in      = {1'b0, ref_ff};
               p_in      = 5'd30;
               lg_sel_in = 1'b0;
               state_in  = gsc_pkg::ST_LOG_NORM;
            end
         end

         gsc_pkg::ST_R0_END: begin
            ref_in         = (quo_ff > {26'd0, gsc_pkg::MAX30}) ? gsc_pkg::MAX30 : quo_ff[29:0];
            calibrating_in = 1'b0;
            status_in      = gsc_pkg::STAT_CALIBRATED;
            load_rsp       = 1'b1;
            state_in       = gsc_pkg::ST_IDLE;
         end

         gsc_pkg::ST_LOG_NORM: begin
            if (m_ff[30]) begin
               it_in    = 5'd0;
               frac_in  = 24'd0;
               state_in = gsc_pkg::ST_LOG_SQ;
            end else begin
               m_in = m_ff << 1;
               p_in = p_ff - 5'd1;
            end
         end

         gsc_pkg::ST_LOG_SQ: begin
            m_in    = t_sq[31] ? t_sq[31:1] : t_sq[30:0];
            frac_in = {frac_ff[22:0], t_sq[31]};
            it_in   = it_ff + 5'd1;
            if (it_ff == 5'(gsc_pkg::FRAC_BITS - 1)) begin
               if (!lg_sel_ff) begin
                  lg0_in    = lg_val;
                  m_in      = {1'b0, rs_ff};
                  p_in      = 5'd30;
                  lg_sel_in = 1'b1;
                  state_in  = gsc_pkg::ST_LOG_NORM;
               end else begin
                  lg1_in   = lg_val;
                  state_in = gsc_pkg::ST_LDIFF;
               end
            end
         end

         gsc_pkg::ST_LDIFF: begin
            neg_in   = ldiff[29];
            mag_in   = ldiff[29] ? 29'(30'd0 - ldiff) : ldiff[28:0];
            state_in = gsc_pkg::ST_MUL;
         end

         gsc_pkg::ST_MUL: begin
            num_in      = {21'd0, prod[34:0]};
            den_in      = 16'd25;
            rem_in      = 16'd0;
            cnt_in      = '0;
            div_next_in = gsc_pkg::ST_E_END;
            state_in    = gsc_pkg::ST_DIV;
         end

         gsc_pkg::ST_E_END: begin
            k_in     = e_val[35:24];
            frac_in  = e_val[23:0];
            r_in     = 31'h4000_0000;
            it_in    = 5'd1;
            state_in = gsc_pkg::ST_EXP;
         end

         gsc_pkg::ST_EXP: begin
            if (frac_ff[23]) begin
               r_in = prod[60:30];
            end
            frac_in = frac_ff << 1;
            it_in   = it_ff + 5'd1;
            if (it_ff == 5'(gsc_pkg::FRAC_BITS)) begin
               state_in = gsc_pkg::ST_SHIFT;
            end
         end

         gsc_pkg::ST_SHIFT: begin
            if (kk > 12'sd20) begin
               status_in = gsc_pkg::STAT_MEASURED;
               conc_in   = 32'hFFFF_FFFF;
               load_rsp  = 1'b1;
               state_in  = gsc_pkg::ST_IDLE;
            end else begin
               num_in      = z9;
               den_in      = 16'd10;
               rem_in      = 16'd0;
               cnt_in      = '0;
               div_next_in = gsc_pkg::ST_C_END;
               state_in    = gsc_pkg::ST_DIV;
            end
         end

         gsc_pkg::ST_C_END: begin
            status_in = gsc_pkg::STAT_MEASURED;
            conc_in   = (quo_ff[gsc_pkg::DIV_W-1:32] != '0) ? 32'hFFFF_FFFF : quo_ff[31:0];
            load_rsp  = 1'b1;
            state_in  = gsc_pkg::ST_IDLE;
         end

         default: begin
            state_in = gsc_pkg::ST_IDLE;
         end
      endcase
   end

   // response register: flags and r0 show the state after the transaction
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      cal_flag_in  = load_rsp ? calibrating_in : cal_flag_ff;
      read_flag_in = load_rsp ? reading_in : read_flag_ff;
      r0_out_in    = load_rsp ? ref_in : r0_out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heat_wait_ff   <= gsc_pkg::HEAT_WAIT_RESET;
         read_wait_ff   <= gsc_pkg::READ_WAIT_RESET;
         divider_ff     <= gsc_pkg::DIVIDER_RESET;
         state_ff       <= gsc_pkg::ST_IDLE;
         calibrating_ff <= 1'b0;
         reading_ff     <= 1'b0;
         countdown_ff   <= 32'd0;
         armed_ff       <= 1'b0;
         ref_ff         <= 30'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         heat_wait_ff   <= heat_wait_in;
         read_wait_ff   <= read_wait_in;
         divider_ff     <= divider_in;
         state_ff       <= state_in;
         calibrating_ff <= calibrating_in;
         reading_ff     <= reading_in;
         countdown_ff   <= countdown_in;
         armed_ff       <= armed_in;
         ref_ff         <= ref_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_next_ff  <= div_next_in;
      kind_ff      <= kind_in;
      sum_ff       <= sum_in;
      rs_ff        <= rs_in;
      num_ff       <= num_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      cnt_ff       <= cnt_in;
      m_ff         <= m_in;
      p_ff         <= p_in;
      frac_ff      <= frac_in;
      it_ff        <= it_in;
      lg_sel_ff    <= lg_sel_in;
      lg0_ff       <= lg0_in;
      lg1_ff       <= lg1_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      k_ff         <= k_in;
      r_ff         <= r_in;
      if (load_rsp) begin
         status_ff <= status_in;
         conc_ff   <= conc_in;
      end
      cal_flag_ff  <= cal_flag_in;
      read_flag_ff <= read_flag_in;
      r0_out_ff    <= r0_out_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_concentration    = conc_ff;
   assign rsp_calibrating_flag = cal_flag_ff;
   assign rsp_reading_flag     = read_flag_ff;
   assign rsp_r0_value         = r0_out_ff;

   // the response slot is empty for the whole of a long transaction
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != gsc_pkg::ST_IDLE) |-> !rsp_valid_ff)
      else $error("response pending while sequencer busy");

   // a long transaction always leaves with its response loaded
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != gsc_pkg::ST_IDLE) ##1 (state_ff == gsc_pkg::ST_IDLE) |-> rsp_valid_ff)
      else $error("sequencer finished without a response");

   // log mantissa stays normalized through the squaring loop
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == gsc_pkg::ST_LOG_SQ) |-> m_ff[30])
      else $error("log mantissa not normalized");

   // a measurement never starts without a reference ratio
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == gsc_pkg::ST_LOG_NORM) |-> (ref_ff != 30'd0))
      else $error("measurement with zero reference");

endmodule
`default_nettype wire
